### hw/rtl/sr5_pkg.sv
// Shared codes for the SOCKS5 request parser: parse states, status, address kinds.
package sr5_pkg;

  // Parse state codes, held in a plain 4-bit vector.
  localparam logic [3:0] PS_VERSION = 4'd0;
  localparam logic [3:0] PS_CMD     = 4'd1;
  localparam logic [3:0] PS_RSV     = 4'd2;
  localparam logic [3:0] PS_ATYP    = 4'd3;
  localparam logic [3:0] PS_DNLEN   = 4'd4;
  localparam logic [3:0] PS_ADDR    = 4'd5;
  localparam logic [3:0] PS_PORT    = 4'd6;
  localparam logic [3:0] PS_ERROR   = 4'd7;
  localparam logic [3:0] PS_END     = 4'd8;

  // Reported phase.
  localparam logic [1:0] PHASE_BUSY  = 2'd0;
  localparam logic [1:0] PHASE_DONE  = 2'd1;
  localparam logic [1:0] PHASE_ERROR = 2'd2;

  // Reply status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_GENERAL = 2'd1;
  localparam logic [1:0] ST_CMD     = 2'd2;
  localparam logic [1:0] ST_ATYP    = 2'd3;

  // Address kinds.
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_IPV4 = 2'd1;
  localparam logic [1:0] KIND_NAME = 2'd2;
  localparam logic [1:0] KIND_IPV6 = 2'd3;

  // Protocol byte values.
  localparam logic [7:0] SOCKS_VERSION = 8'h05;
  localparam logic [7:0] CMD_CONNECT   = 8'h01;
  localparam logic [7:0] RSV_BYTE      = 8'h00;
  localparam logic [7:0] ATYP_IPV4     = 8'h01;
  localparam logic [7:0] ATYP_NAME     = 8'h03;
  localparam logic [7:0] ATYP_IPV6     = 8'h04;

  // Address lengths of the fixed-size kinds.
  localparam logic [7:0] LEN_IPV4 = 8'd4;
  localparam logic [7:0] LEN_IPV6 = 8'd16;

  // Number of port bytes.
  localparam logic [7:0] PORT_BYTES = 8'd2;

endpackage

### hw/rtl/socks5_request_parser.sv
// SOCKS5 request parser: checks a request byte by byte and reports its fields.
//
// The block takes one beat per request byte on the input channel (in_valid_i,
// in_stall_o, action_i, data_byte_i). With action_i low the byte is parsed;
// with action_i high the parser restarts and the byte is ignored. Every input
// beat produces exactly one result beat on the output channel (out_valid_o,
// out_stall_i and the result fields).
//
// A result carries the phase (parsing, complete or error), the reply status,
// and, for destination address bytes, the byte with its index within the
// address. The address kind, expected address length and the big-endian port
// accumulated so far are shown with every result.
//
// A beat's result is registered and valid in the cycle after its acceptance.
// One beat is accepted every cycle while no waiting result is stalled; the
// rate is set by the single result register, refilled in the cycle it is
// emptied. When the receiver stalls a waiting result, the result holds and
// in_stall_o rises in the same cycle, so no beat is lost. Reset puts the parser
// in the state that expects the version byte, with status general failure, no
// address kind, zero length and port, and an empty result register.
module socks5_request_parser
  import sr5_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  phase_o,
  output logic [1:0]  status_o,
  output logic        addr_valid_o,
  output logic [7:0]  addr_byte_o,
  output logic [7:0]  addr_index_o,
  output logic [1:0]  addr_kind_o,
  output logic [7:0]  addr_length_o,
  output logic [15:0] dest_port_o
);

  // Parser state.
  logic [3:0]  pstate_q, pstate_d;
  logic [1:0]  fail_q, fail_d;
  logic [1:0]  kind_q, kind_d;
  logic [7:0]  exp_len_q, exp_len_d;
  logic [7:0]  count_q, count_d;
  logic [15:0] port_q, port_d;

  // Result register.
  logic        out_valid_q;
  logic [1:0]  phase_q, phase_d;
  logic        av_q, av_d;
  logic [7:0]  ab_q, ab_d;
  logic [7:0]  ai_q, ai_d;

  logic        in_fire;
  logic [7:0]  count_inc;

  // The result register can take a new beat unless it holds one being stalled.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign count_inc  = count_q + 8'd1;

  always_comb begin
    pstate_d  = pstate_q;
    fail_d    = fail_q;
    kind_d    = kind_q;
    exp_len_d = exp_len_q;
    count_d   = count_q;
    port_d    = port_q;
    av_d      = 1'b0;
    ab_d      = 8'd0;
    ai_d      = 8'd0;

    if (action_i) begin
      pstate_d  = PS_VERSION;
      fail_d    = ST_GENERAL;
      kind_d    = KIND_NONE;
      exp_len_d = 8'd0;
      count_d   = 8'd0;
      port_d    = 16'd0;
    end else begin
      case (pstate_q)
        PS_VERSION: begin
          if (data_byte_i == SOCKS_VERSION) begin
            pstate_d = PS_CMD;
          end else begin
            pstate_d = PS_ERROR;
            fail_d   = ST_GENERAL;
          end
        end
        PS_CMD: begin
          if (data_byte_i == CMD_CONNECT) begin
            pstate_d = PS_RSV;
          end else begin
            pstate_d = PS_ERROR;
            fail_d   = ST_CMD;
          end
        end
        PS_RSV: begin
          if (data_byte_i == RSV_BYTE) begin
            pstate_d = PS_ATYP;
          end else begin
            pstate_d = PS_ERROR;
            fail_d   = ST_GENERAL;
          end
        end
        PS_ATYP: begin
          if (data_byte_i == ATYP_IPV4) begin
            kind_d    = KIND_IPV4;
            exp_len_d = LEN_IPV4;
            count_d   = 8'd0;
            pstate_d  = PS_ADDR;
          end else if (data_byte_i == ATYP_IPV6) begin
            kind_d    = KIND_IPV6;
            exp_len_d = LEN_IPV6;
            count_d   = 8'd0;
            pstate_d  = PS_ADDR;
          end else if (data_byte_i == ATYP_NAME) begin
            kind_d   = KIND_NAME;
            pstate_d = PS_DNLEN;
          end else begin
            pstate_d = PS_ERROR;
            fail_d   = ST_ATYP;
          end
        end
        PS_DNLEN: begin
          exp_len_d = data_byte_i;
          count_d   = 8'd0;
          // An empty domain name cannot be parsed, so it is rejected.
          if (data_byte_i == 8'd0) begin
            pstate_d = PS_ERROR;
            fail_d   = ST_GENERAL;
          end else begin
            pstate_d = PS_ADDR;
          end
        end
        PS_ADDR: begin
          av_d = 1'b1;
          ab_d = data_byte_i;
          ai_d = count_q;
          if (count_inc == exp_len_q) begin
            count_d  = 8'd0;
            pstate_d = PS_PORT;
          end else begin
            count_d = count_inc;
          end
        end
        PS_PORT: begin
          port_d  = {port_q[7:0], data_byte_i};
          count_d = count_inc;
          if (count_inc >= PORT_BYTES) begin
            fail_d   = ST_OK;
            pstate_d = PS_END;
          end
        end
        default: begin
          // Complete or failed: the byte is dropped until a restart.
        end
      endcase
    end

    case (pstate_d)
      PS_END:   phase_d = PHASE_DONE;
      PS_ERROR: phase_d = PHASE_ERROR;
      default:  phase_d = PHASE_BUSY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pstate_q    <= PS_VERSION;
      fail_q      <= ST_GENERAL;
      kind_q      <= KIND_NONE;
      exp_len_q   <= 8'd0;
      count_q     <= 8'd0;
      port_q      <= 16'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pstate_q  <= pstate_d;
        fail_q    <= fail_d;
        kind_q    <= kind_d;
        exp_len_q <= exp_len_d;
        count_q   <= count_d;
        port_q    <= port_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-beat result fields; the rest of the result is read from the state.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      phase_q <= phase_d;
      av_q    <= av_d;
      ab_q    <= ab_d;
      ai_q    <= ai_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign phase_o       = phase_q;
  assign status_o      = fail_q;
  assign addr_valid_o  = av_q;
  assign addr_byte_o   = ab_q;
  assign addr_index_o  = ai_q;
  assign addr_kind_o   = kind_q;
  assign addr_length_o = exp_len_q;
  assign dest_port_o   = port_q;

endmodule

### hw/rtl/sr5_checker.sv
// Port-level checks for the SOCKS5 request parser, bound to the top level.
module sr5_checker
  import sr5_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [1:0]  phase_o,
  input logic [1:0]  status_o,
  input logic        addr_valid_o,
  input logic [7:0]  addr_byte_o,
  input logic [7:0]  addr_index_o,
  input logic [1:0]  addr_kind_o,
  input logic [7:0]  addr_length_o,
  input logic [15:0] dest_port_o
);

  // A stalled result beat stays and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(phase_o) &&
      $stable(status_o) && $stable(addr_valid_o) && $stable(addr_byte_o) &&
      $stable(addr_index_o) && $stable(dest_port_o))
    else $error("result beat changed while stalled");

  // Address bytes appear only while parsing, after a kind is known, in range.
  a_addr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && addr_valid_o |-> phase_o == PHASE_BUSY &&
      addr_kind_o != KIND_NONE && addr_index_o < addr_length_o)
    else $error("address byte outside of the address field");

  // A complete request always reports success.
  a_done_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == PHASE_DONE |-> status_o == ST_OK)
    else $error("complete request without success status");

  // While parsing, the status stays at general failure.
  a_busy_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_o == PHASE_BUSY |-> status_o == ST_GENERAL)
    else $error("status changed before the request ended");

endmodule

bind socks5_request_parser sr5_checker u_sr5_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .phase_o       (phase_o),
  .status_o      (status_o),
  .addr_valid_o  (addr_valid_o),
  .addr_byte_o   (addr_byte_o),
  .addr_index_o  (addr_index_o),
  .addr_kind_o   (addr_kind_o),
  .addr_length_o (addr_length_o),
  .dest_port_o   (dest_port_o)
);
